// File: rtl/pspt_pkg.sv
// Package for the paired solenoid pulse timer.
// Field widths, command codes, register indexes and the pulse scale factor.
// No dependencies.
package pspt_pkg;

	localparam int NumCoils  = 8;
	localparam int NumPairs  = NumCoils / 2;
	localparam int CmdW      = 2;
	localparam int ChanW     = 3;
	localparam int VelW      = 7;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 8;
	localparam int CountW    = 16;

	// Multiplies the pulse length in units to get ticks (1..64)
	localparam int unsigned OnTimeScale = 1;

	localparam logic [CmdW-1:0] CMD_TICK    = 2'd0;
	localparam logic [CmdW-1:0] CMD_TRIGGER = 2'd1;
	localparam logic [CmdW-1:0] CMD_KILL    = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_MIN_ON  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_ON  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PAIRMOD = 2'd2;

	// ceil(2^22 / 126): exact floor(x/126) for every x below 2^15
	localparam int         RecipShift = 22;
	localparam logic [15:0] Recip126  = 16'd33289;

	typedef logic [CountW-1:0] count_t;

endpackage

// File: rtl/paired_solenoid_pulse_timer.sv
// Top level of the paired solenoid pulse timer: pulse length pipeline,
// per-coil countdown state and the registered mask outputs.
// Depends on pspt_pkg.

// Paired solenoid pulse timer. Eight coils in four pairs (pair p: odd coil
// on channel 2p, even coil on channel 2p+1). Each command beat is a tick
// (counts pulses down and expires them), a trigger (starts a pulse whose
// length follows from velocity and the min/max on-time registers) or a kill.
// Every command beat yields exactly one result beat carrying the coil, hold
// and active masks after that command. Throughput is one beat per cycle while
// the result side keeps res_ready high. Each beat passes an input register,
// a stage for the velocity product, a stage for the division by 126
// (reciprocal multiply) and the scale, then the state update that loads the
// result register. Each stage has its own ready, so empty stages keep taking
// beats while a result waits. Configuration writes apply at once and are meant
// to be done while no beat is in flight.
module paired_solenoid_pulse_timer (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [pspt_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [pspt_pkg::CfgDataW-1:0]    cfg_data,
	// command channel
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  logic [pspt_pkg::CmdW-1:0]        cmd,
	input  logic [pspt_pkg::ChanW-1:0]       channel,
	input  logic [pspt_pkg::VelW-1:0]        velocity,
	// result channel
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [pspt_pkg::NumCoils-1:0]    coil_on,
	output logic [pspt_pkg::NumPairs-1:0]    return_hold,
	output logic [pspt_pkg::NumCoils-1:0]    active
);
	import pspt_pkg::*;

	// ---------------- configuration ----------------
	logic [7:0]          min_on_q;
	logic [7:0]          max_on_q;
	logic [NumPairs-1:0] pair_modes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_on_q     <= 8'd1;
			max_on_q     <= 8'd255;
			pair_modes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_ON: begin
					// clamp into 1..254
					if (cfg_data == 8'd0)
						min_on_q <= 8'd1;
					else if (cfg_data == 8'd255)
						min_on_q <= 8'd254;
					else
						min_on_q <= cfg_data;
				end
				REG_MAX_ON: begin
					// clamp to at least 2
					if (cfg_data < 8'd2)
						max_on_q <= 8'd2;
					else
						max_on_q <= cfg_data;
				end
				REG_PAIRMOD: pair_modes_q <= cfg_data[NumPairs-1:0];
				default: ; // unused index: ignored
			endcase
		end
	end

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, v_s3, res_valid_q;
	logic rdy_out, rdy3, rdy2, rdy1;

	assign rdy_out   = !res_valid_q || res_ready;
	assign rdy3      = !v_s3 || rdy_out;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign cmd_ready = rdy1;

	logic fire_out;
	assign fire_out = v_s3 && rdy_out;

	// ---------------- stage 1: input register ----------------
	logic [CmdW-1:0]  cmd_s1;
	logic [ChanW-1:0] ch_s1;
	logic [VelW-1:0]  vel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && cmd_valid) begin
			cmd_s1 <= cmd;
			ch_s1  <= channel;
			vel_s1 <= velocity;
		end
	end

	// ---------------- stage 2: (v-1) * |max-min| ----------------
	// The quotient truncates toward zero, so the division works on the
	// magnitude and the sign is applied when min is added back.
	logic [VelW-1:0] vm1;
	logic [7:0]      span_mag;
	logic            span_neg;
	logic [14:0]     prod;

	assign vm1      = vel_s1 - VelW'(1);
	assign span_neg = max_on_q < min_on_q;
	assign span_mag = span_neg ? (min_on_q - max_on_q) : (max_on_q - min_on_q);
	assign prod     = 15'(vm1) * 15'(span_mag);

	logic [CmdW-1:0]  cmd_s2;
	logic [ChanW-1:0] ch_s2;
	logic [14:0]      prod_s2;
	logic             neg_s2;
	logic             velz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cmd_s2  <= cmd_s1;
			ch_s2   <= ch_s1;
			prod_s2 <= prod;
			neg_s2  <= span_neg;
			velz_s2 <= (vel_s1 == '0);
		end
	end

	// ---------------- stage 3: divide by 126, add min, scale ----------------
	logic [30:0]  recip_prod;
	logic [8:0]   quot;
	logic [8:0]   units;
	logic [31:0]  scaled;
	count_t       len;

	assign recip_prod = 31'(prod_s2) * 31'(Recip126);
	assign quot       = recip_prod[RecipShift +: 9];
	// units stays within 1..255 for any legal min/max pair
	assign units      = neg_s2 ? ({1'b0, min_on_q} - quot) : ({1'b0, min_on_q} + quot);
	assign scaled     = 32'(units) * 32'(OnTimeScale);
	assign len        = velz_s2 ? '0 : scaled[CountW-1:0];

	logic [CmdW-1:0]  cmd_s3;
	logic [ChanW-1:0] ch_s3;
	count_t           len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			cmd_s3 <= cmd_s2;
			ch_s3  <= ch_s2;
			len_s3 <= len;
		end
	end

	// ---------------- coil state ----------------
	count_t              rem_q   [NumCoils];
	logic [NumCoils-1:0] busy_q;
	logic [NumCoils-1:0] drive_q;
	logic [NumPairs-1:0] hold_q;

	count_t              rem_n   [NumCoils];
	logic [NumCoils-1:0] busy_n;
	logic [NumCoils-1:0] drive_n;
	logic [NumPairs-1:0] hold_n;

	logic [1:0]      pair_sel;
	logic            sel_paired;
	logic [ChanW-1:0] odd_ch;
	logic [ChanW-1:0] even_ch;

	assign pair_sel   = ch_s3[ChanW-1:1];
	assign sel_paired = pair_modes_q[pair_sel];
	assign odd_ch     = {pair_sel, 1'b0};
	assign even_ch    = {pair_sel, 1'b1};

	always_comb begin
		rem_n   = rem_q;
		busy_n  = busy_q;
		drive_n = drive_q;
		hold_n  = hold_q;
		case (cmd_s3)
			CMD_TICK: begin
				for (int c = 0; c < NumCoils; c++)
					if (rem_q[c] != '0)
						rem_n[c] = rem_q[c] - count_t'(1);
				for (int p = 0; p < NumPairs; p++) begin
					if (!pair_modes_q[p]) begin
						if (rem_n[2*p] == '0) begin
							busy_n[2*p]  = 1'b0;
							drive_n[2*p] = 1'b0;
						end
						if (rem_n[2*p+1] == '0) begin
							busy_n[2*p+1]  = 1'b0;
							drive_n[2*p+1] = 1'b0;
							hold_n[p]      = 1'b0;
						end
					end else if (rem_n[2*p] == '0) begin
						// attack done: drop both coils, enter return hold
						busy_n[2*p]    = 1'b0;
						busy_n[2*p+1]  = 1'b0;
						drive_n[2*p]   = 1'b0;
						drive_n[2*p+1] = 1'b0;
						hold_n[p]      = 1'b1;
					end else begin
						drive_n[2*p]   = 1'b1;
						drive_n[2*p+1] = 1'b0;
						hold_n[p]      = 1'b0;
					end
				end
			end
			CMD_TRIGGER: begin
				if (sel_paired) begin
					// either coil fires the odd (attack) coil
					rem_n[odd_ch]    = len_s3;
					rem_n[even_ch]   = '0;
					busy_n[odd_ch]   = 1'b1;
					busy_n[even_ch]  = 1'b1;
					drive_n[odd_ch]  = 1'b1;
					drive_n[even_ch] = 1'b0;
					hold_n[pair_sel] = 1'b0;
				end else begin
					rem_n[ch_s3]   = len_s3;
					busy_n[ch_s3]  = 1'b1;
					drive_n[ch_s3] = 1'b1;
					if (ch_s3[0])
						hold_n[pair_sel] = 1'b0;
				end
			end
			CMD_KILL: begin
				rem_n[ch_s3]   = '0;
				busy_n[ch_s3]  = 1'b0;
				drive_n[ch_s3] = 1'b0;
				if (ch_s3[0])
					hold_n[pair_sel] = 1'b0;
			end
			default: ; // unused command: masks only
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumCoils; c++)
				rem_q[c] <= '0;
			busy_q  <= '0;
			drive_q <= '0;
			hold_q  <= '0;
		end else if (fire_out) begin
			rem_q   <= rem_n;
			busy_q  <= busy_n;
			drive_q <= drive_n;
			hold_q  <= hold_n;
		end
	end

	// ---------------- result register ----------------
	logic [NumCoils-1:0] coil_q;
	logic [NumPairs-1:0] hold_out_q;
	logic [NumCoils-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (rdy_out)
			res_valid_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (fire_out) begin
			coil_q     <= drive_n;
			hold_out_q <= hold_n;
			active_q   <= busy_n;
		end
	end

	assign res_valid   = res_valid_q;
	assign coil_on     = coil_q;
	assign return_hold = hold_out_q;
	assign active      = active_q;

endmodule

// File: tb/tb_paired_solenoid_pulse_timer.sv
// Self-checking testbench for the paired solenoid pulse timer.
// Holds its own model of the coil, hold and busy state and checks every result beat.
// Depends on pspt_pkg and paired_solenoid_pulse_timer.
module tb_paired_solenoid_pulse_timer;
	timeunit 1ns;
	timeprecision 1ps;

	import pspt_pkg::*;

	// Codes the package leaves unnamed: the spare command and the spare register slot.
	localparam logic [CmdW-1:0]    CMD_UNUSED = 2'd3;
	localparam logic [CfgIdxW-1:0] REG_SPARE  = 2'd3;

	// Cap on printed mismatch lines. Every mismatch is still counted.
	localparam int MaxReports = 40;

	typedef struct packed {
		logic [NumCoils-1:0] coil;
		logic [NumPairs-1:0] hold;
		logic [NumCoils-1:0] act;
	} mask_set_t;

	// ---------------------------------------------------------------- DUT ports
	// Every input starts at a known value. Reset is held low from time zero.
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	logic [CmdW-1:0]     cmd       = CMD_TICK;
	logic [ChanW-1:0]    channel   = '0;
	logic [VelW-1:0]     velocity  = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	logic [NumCoils-1:0] coil_on;
	logic [NumPairs-1:0] return_hold;
	logic [NumCoils-1:0] active;

	paired_solenoid_pulse_timer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.channel    (channel),
		.velocity   (velocity),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.coil_on    (coil_on),
		.return_hold(return_hold),
		.active     (active)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------- predicted state
	// Mirror of the block: per-coil countdown, busy and full-drive flags, per-pair
	// return hold, plus the three registers as the block holds them after clamping.
	count_t              ticks_left [NumCoils];
	logic                busy       [NumCoils];
	logic                drive      [NumCoils];
	logic                pair_hold  [NumPairs];
	logic [7:0]          min_units;
	logic [7:0]          max_units;
	logic [NumPairs-1:0] paired_mask;

	// Masks expected on the result channel, oldest first.
	mask_set_t expected_masks[$];

	// Idling controls, changed per phase. Zero turns that side's idling off.
	int gap_max     = 0;
	int stall_max   = 0;
	int burst_left  = 0;
	int ready_run   = 0;

	// Counters for the summary and the verdict.
	int mismatches   = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int n_tick       = 0;
	int n_trigger    = 0;
	int n_kill       = 0;
	int n_unused     = 0;
	int n_expired    = 0;

	function automatic void reset_model();
		for (int c = 0; c < NumCoils; c++) begin
			ticks_left[c] = '0;
			busy[c]       = 1'b0;
			drive[c]      = 1'b0;
		end
		for (int p = 0; p < NumPairs; p++)
			pair_hold[p] = 1'b0;
		min_units   = 8'd1;
		max_units   = 8'd255;
		paired_mask = '0;
	endfunction

	// Pulse length in ticks: linear in velocity between min (velocity 1) and
	// max (velocity 127), signed quotient truncated toward zero. Velocity 0 is
	// a zero-length pulse. A falling slope (max below min) is legal.
	function automatic count_t pulse_ticks(input logic [VelW-1:0] vel);
		int lo;
		int hi;
		int units;
		if (vel == '0)
			return '0;
		lo    = int'(min_units);
		hi    = int'(max_units);
		units = (int'(vel) - 1) * (hi - lo) / 126 + lo;
		if (units < 0)
			units = 0;
		return count_t'(units * int'(OnTimeScale));
	endfunction

	// Millisecond tick. All running counts drop by one first, then each pair
	// is resolved by its mode. In normal mode an expired coil (count now zero,
	// idle coils included) drops busy and drive; the even coil also drops the
	// pair's hold. In paired mode only the odd (attack) coil's count matters:
	// expired means both coils released and the pair enters return hold,
	// otherwise the attack coil is forced on and hold is cleared.
	function automatic void advance_tick();
		int odd;
		int even;
		for (int c = 0; c < NumCoils; c++)
			if (ticks_left[c] != '0)
				ticks_left[c] = ticks_left[c] - count_t'(1);
		for (int p = 0; p < NumPairs; p++) begin
			odd  = 2 * p;
			even = 2 * p + 1;
			if (!paired_mask[p]) begin
				if (ticks_left[odd] == '0) begin
					if (busy[odd])
						n_expired++;
					busy[odd]  = 1'b0;
					drive[odd] = 1'b0;
				end
				if (ticks_left[even] == '0) begin
					if (busy[even])
						n_expired++;
					busy[even]   = 1'b0;
					drive[even]  = 1'b0;
					pair_hold[p] = 1'b0;
				end
			end else if (ticks_left[odd] == '0) begin
				if (busy[odd])
					n_expired++;
				busy[odd]    = 1'b0;
				busy[even]   = 1'b0;
				drive[odd]   = 1'b0;
				drive[even]  = 1'b0;
				pair_hold[p] = 1'b1;
			end else begin
				drive[odd]   = 1'b1;
				drive[even]  = 1'b0;
				pair_hold[p] = 1'b0;
			end
		end
	endfunction

	// Trigger. In paired mode either channel fires the attack coil of its pair
	// and parks the return coil busy but undriven.
	function automatic void start_pulse(input logic [ChanW-1:0] ch, input logic [VelW-1:0] vel);
		int     p;
		int     odd;
		count_t len;
		p   = int'(ch) / 2;
		odd = 2 * p;
		len = pulse_ticks(vel);
		if (paired_mask[p]) begin
			ticks_left[odd]     = len;
			ticks_left[odd + 1] = '0;
			busy[odd]           = 1'b1;
			busy[odd + 1]       = 1'b1;
			drive[odd]          = 1'b1;
			drive[odd + 1]      = 1'b0;
			pair_hold[p]        = 1'b0;
		end else begin
			ticks_left[ch] = len;
			busy[ch]       = 1'b1;
			drive[ch]      = 1'b1;
			if (ch[0])
				pair_hold[p] = 1'b0;
		end
	endfunction

	// Kill: same in both modes. Killing a paired attack coil leaves the pair to
	// fall into return hold on the next tick.
	function automatic void kill_pulse(input logic [ChanW-1:0] ch);
		ticks_left[ch] = '0;
		busy[ch]       = 1'b0;
		drive[ch]      = 1'b0;
		if (ch[0])
			pair_hold[int'(ch) / 2] = 1'b0;
	endfunction

	function automatic mask_set_t current_masks();
		mask_set_t m;
		for (int c = 0; c < NumCoils; c++) begin
			m.coil[c] = drive[c];
			m.act[c]  = busy[c];
		end
		for (int p = 0; p < NumPairs; p++)
			m.hold[p] = pair_hold[p];
		return m;
	endfunction

	// Applies one command to the model and queues the masks it must produce.
	function automatic void predict_command(input logic [CmdW-1:0] c, input logic [ChanW-1:0] ch,
			input logic [VelW-1:0] vel);
		case (c)
			CMD_TICK: begin
				n_tick++;
				advance_tick();
			end
			CMD_TRIGGER: begin
				n_trigger++;
				start_pulse(ch, vel);
			end
			CMD_KILL: begin
				n_kill++;
				kill_pulse(ch);
			end
			default: n_unused++;  // spare code: state untouched, masks still returned
		endcase
		expected_masks.push_back(current_masks());
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("[%0t] mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
	endtask

	// ------------------------------------------------------------- monitor
	// Sampled at the rising edge. Accepted command beats feed the model first,
	// then any accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin : watch_channels
		mask_set_t want;
		if (arst_n && cmd_valid && cmd_ready)
			predict_command(cmd, channel, velocity);
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (expected_masks.size() == 0) begin
				report_mismatch("result beat with none pending (coil_on)", coil_on, 8'h00);
			end else begin
				want = expected_masks.pop_front();
				if (coil_on !== want.coil)
					report_mismatch("coil_on", coil_on, want.coil);
				if (return_hold !== want.hold)
					report_mismatch("return_hold", 8'(return_hold), 8'(want.hold));
				if (active !== want.act)
					report_mismatch("active", active, want.act);
			end
		end
	end

	// ------------------------------------------------------------- receiver
	// Alternates runs of ready with stall runs whose length stall_max bounds.
	// After a stall it always goes back to ready.
	always @(negedge clk) begin
		if (ready_run > 0) begin
			ready_run--;
		end else if (stall_max == 0 || !res_ready) begin
			res_ready <= 1'b1;
			ready_run = $urandom_range(1, 30);
		end else begin
			res_ready <= 1'b0;
			ready_run = $urandom_range(1, stall_max);
		end
	end

	// --------------------------------------------------------------- sender
	// Sends one command beat. Entered and left at a falling edge. Beats go out
	// in bursts; between bursts valid drops for a random gap when idling is on.
	task automatic send_command(input logic [CmdW-1:0] c, input logic [ChanW-1:0] ch,
			input logic [VelW-1:0] vel);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap        = $urandom_range(1, gap_max);
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		cmd_valid <= 1'b1;
		cmd       <= c;
		channel   <= ch;
		velocity  <= vel;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Holds the sender off until every queued result has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (expected_masks.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register write; only called with nothing in flight. The model keeps the
	// value as the block clamps it.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_writes++;
		case (idx)
			REG_MIN_ON:  min_units   = (data == 8'd0) ? 8'd1 : (data == 8'd255) ? 8'd254 : data;
			REG_MAX_ON:  max_units   = (data < 8'd2) ? 8'd2 : data;
			REG_PAIRMOD: paired_mask = data[NumPairs-1:0];
			default: ;  // spare slot: no register behind it
		endcase
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- tests
	// Normal mode at reset settings (min 1, max 255): longest and shortest
	// pulses, the zero-velocity pulse, expiry on the first tick, kills on both
	// coil types and the spare command code.
	task automatic test_normal_pulses();
		send_command(CMD_TRIGGER, 3'd0, 7'd127);  // 255 ticks
		send_command(CMD_TRIGGER, 3'd1, 7'd0);    // zero length
		send_command(CMD_TRIGGER, 3'd2, 7'd1);    // one tick
		send_command(CMD_TRIGGER, 3'd5, 7'd64);
		send_command(CMD_TICK,    3'd7, 7'd127);  // channels 1 and 2 expire
		send_command(CMD_KILL,    3'd0, 7'd0);
		send_command(CMD_KILL,    3'd5, 7'd127);
		send_command(CMD_UNUSED,  3'd7, 7'd127);
	endtask

	// Paired mode on every pair: trigger through the return coil, attack
	// expiry into return hold, retrigger clearing hold, an attack kill that
	// drops into hold on the next tick, a return-coil kill clearing hold, and
	// a mode change with pulses still running.
	task automatic test_paired_mode();
		wait_drained();
		write_reg(REG_PAIRMOD, 8'h0F);
		send_command(CMD_TRIGGER, 3'd1, 7'd1);
		send_command(CMD_TICK,    3'd0, 7'd0);    // pair 0 attack expires
		send_command(CMD_TRIGGER, 3'd3, 7'd127);
		send_command(CMD_TICK,    3'd0, 7'd0);    // pair 1 still running
		send_command(CMD_TRIGGER, 3'd0, 7'd2);    // clears pair 0 hold
		send_command(CMD_KILL,    3'd2, 7'd0);
		send_command(CMD_TICK,    3'd0, 7'd0);    // pair 1 falls into hold
		send_command(CMD_KILL,    3'd3, 7'd0);
		send_command(CMD_KILL,    3'd1, 7'd0);
		wait_drained();
		write_reg(REG_PAIRMOD, 8'h00);
		send_command(CMD_TICK,    3'd0, 7'd0);
	endtask

	// Register clamps at both ends, a falling slope, the spare register slot
	// and a mode write with high bits set.
	task automatic test_register_extremes();
		wait_drained();
		write_reg(REG_MIN_ON, 8'd0);    // clamps to 1
		write_reg(REG_MAX_ON, 8'd1);    // clamps to 2
		send_command(CMD_TRIGGER, 3'd4, 7'd127);
		send_command(CMD_TRIGGER, 3'd6, 7'd1);
		wait_drained();
		write_reg(REG_MIN_ON, 8'd255);  // clamps to 254
		write_reg(REG_MAX_ON, 8'd0);    // clamps to 2, slope now negative
		write_reg(REG_SPARE,  8'hFF);
		write_reg(REG_PAIRMOD, 8'hF5);  // only the low nibble lands
		send_command(CMD_TRIGGER, 3'd7, 7'd127);
		send_command(CMD_TRIGGER, 3'd0, 7'd64);
		send_command(CMD_TICK,    3'd0, 7'd0);
		send_command(CMD_TICK,    3'd0, 7'd0);
	endtask

	// One random phase: new register settings and idling, then a tick-heavy
	// mix so pulses actually run out. Optionally drains halfway through.
	task automatic run_random_phase(input int count, input logic [7:0] lo, input logic [7:0] hi,
			input logic [NumPairs-1:0] modes, input int vel_top, input int gap, input int stall,
			input bit pause_midway);
		logic [CmdW-1:0] c;
		int              roll;
		wait_drained();
		write_reg(REG_MIN_ON, lo);
		write_reg(REG_MAX_ON, hi);
		write_reg(REG_PAIRMOD, 8'(modes));
		gap_max    = gap;
		stall_max  = stall;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < 50)
				c = CMD_TICK;
			else if (roll < 82)
				c = CMD_TRIGGER;
			else if (roll < 96)
				c = CMD_KILL;
			else
				c = CMD_UNUSED;
			send_command(c, ChanW'($urandom_range(0, NumCoils - 1)),
				VelW'($urandom_range(0, vel_top)));
		end
	endtask

	// Settings run from short pulses with no idling at all, through all-paired,
	// random modes, near-maximum lengths, low velocities on the full span, to a
	// falling slope, with idling on both sides in most phases.
	task automatic test_random_traffic();
		run_random_phase(150, 8'd1,   8'd4,   4'h0, 127, 0,  0,  1'b0);
		run_random_phase(150, 8'd2,   8'd9,   4'hF, 127, 6,  5,  1'b1);
		run_random_phase(150, 8'($urandom_range(1, 8)), 8'($urandom_range(2, 16)),
			4'($urandom_range(0, 15)), 127, 12, 10, 1'b0);
		run_random_phase(150, 8'd254, 8'd255, 4'h5, 127, 3,  2,  1'b0);
		run_random_phase(150, 8'd1,   8'd255, 4'hA, 3,   8,  14, 1'b0);
		run_random_phase(150, 8'd200, 8'd3,   4'($urandom_range(0, 15)), 127, 4, 8, 1'b0);
	endtask

	// ----------------------------------------------------------------- main
	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_normal_pulses();
		test_paired_mode();
		test_register_extremes();
		test_random_traffic();

		// Let the pipeline empty, then keep watching for stray beats.
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d ticks, %0d triggers, %0d kills and %0d spare commands; %0d expiries.",
			n_tick, n_trigger, n_kill, n_unused, n_expired);
		$display("Compared %0d result beats across %0d register writes; %0d mismatches.",
			results_seen, reg_writes, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: a correct run finishes well inside a third of this.
	initial begin
		#3ms;
		$display("Timeout with %0d results still pending.", expected_masks.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
